FILE: hdl/i2cmts_pkg.sv
package i2cmts_pkg;

  localparam int unsigned BUF_DEPTH_DEFAULT = 16;

  localparam int unsigned OQ_DEPTH = 3;
  localparam int unsigned OQ_IDX_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_LVL_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WR_BUF = 2'd0,
    CMD_START  = 2'd1,
    CMD_EVENT  = 2'd2,
    CMD_RD_BUF = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OC_PENDING = 2'd0,
    OC_SUCCESS = 2'd1,
    OC_FAILED  = 2'd2
  } outcome_t;

  localparam logic [7:0] STATUS_MASK     = 8'hFC;
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_RSTART       = 8'h10;
  localparam logic [7:0] ST_TX_ADDR_ACK  = 8'h18;
  localparam logic [7:0] ST_TX_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST     = 8'h38;
  localparam logic [7:0] ST_RX_ADDR_ACK  = 8'h40;
  localparam logic [7:0] ST_RX_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_RX_DATA_NACK = 8'h58;

  localparam logic [5:0] CW_EN  = 6'h01;
  localparam logic [5:0] CW_IE  = 6'h02;
  localparam logic [5:0] CW_INT = 6'h04;
  localparam logic [5:0] CW_ACK = 6'h08;
  localparam logic [5:0] CW_STA = 6'h10;
  localparam logic [5:0] CW_STO = 6'h20;

  typedef struct packed {
    logic       ctrl_valid;
    logic [5:0] ctrl_word;
    logic       tx_valid;
    logic [7:0] tx_data;
    outcome_t   outcome;
    logic [7:0] fail_status;
    logic       busy_res;
    logic [7:0] read_data;
  } res_t;

endpackage

FILE: hdl/i2cmts_channels.sv
interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] index;
  logic [7:0] data;
  logic [4:0] msg_size;
  logic [7:0] status;

  modport source (output valid, cmd, index, data, msg_size, status, input ready);
  modport sink   (input valid, cmd, index, data, msg_size, status, output ready);
endinterface

interface i2cmts_out_if;
  logic       valid;
  logic       ready;
  logic       ctrl_valid;
  logic [5:0] ctrl_word;
  logic       tx_valid;
  logic [7:0] tx_data;
  logic [1:0] outcome;
  logic [7:0] fail_status;
  logic       busy_res;
  logic [7:0] read_data;

  modport source (output valid, ctrl_valid, ctrl_word, tx_valid, tx_data, outcome,
                  fail_status, busy_res, read_data, input ready);
  modport sink   (input valid, ctrl_valid, ctrl_word, tx_valid, tx_data, outcome,
                  fail_status, busy_res, read_data, output ready);
endinterface

FILE: hdl/i2cmts_core.sv
module i2cmts_core import i2cmts_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUF_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  i2cmts_in_if.sink           in_ch,
  input  logic [OQ_LVL_W-1:0] oq_level,
  output logic                res_valid,
  output res_t                res
);

  localparam int unsigned PW    = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
  localparam int unsigned CMP_W = (PW > 5) ? PW : 5;
  localparam int unsigned XW    = CMP_W + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);
  localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);
  localparam logic [OQ_LVL_W:0] OQ_FULL = (OQ_LVL_W + 1)'(OQ_DEPTH);

  logic [PW-1:0] ptr_r, ptr_nxt, len_r, len_nxt;
  outcome_t      oc_r, oc_nxt;
  logic [7:0]    fst_r, fst_nxt;
  logic          busy_r, busy_nxt;

  logic            acc;
  logic [7:0]      stat;
  logic            idx_ok, ptr_lt;
  logic [PW-1:0]   base_p, adv_p, rx_p;
  logic [XW-1:0]   base_x, len_x, msz_x, idx_x, rx_x;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd, mem_q;
  logic [7:0]    mem [BUFFER_DEPTH];

  logic       ctrl_v, tx_v, rd_v;
  logic [5:0] cword;

  logic       b_valid_r;
  logic       b_ctrl_v_r, b_tx_r, b_rd_r, b_busy_r;
  logic [5:0] b_cword_r;
  outcome_t   b_oc_r;
  logic [7:0] b_fst_r;

  assign in_ch.ready = ((OQ_LVL_W + 1)'(oq_level) + (OQ_LVL_W + 1)'(b_valid_r)) < OQ_FULL;
  assign acc         = in_ch.valid && in_ch.ready;

  assign stat   = in_ch.status & STATUS_MASK;
  assign idx_x  = XW'(in_ch.index);
  assign msz_x  = XW'(in_ch.msg_size);
  assign len_x  = XW'(len_r);
  assign idx_ok = idx_x < DEPTH_X;
  assign ptr_lt = ptr_r < DEPTH_P;
  assign adv_p  = ptr_lt ? ptr_r + PW'(1) : ptr_r;
  assign base_p = (stat == ST_START || stat == ST_RSTART) ? '0 : ptr_r;
  assign base_x = XW'(base_p);
  assign rx_p   = (stat == ST_RX_DATA_ACK) ? adv_p : ptr_r;
  assign rx_x   = XW'(rx_p);

  always_comb begin
    ptr_nxt  = ptr_r;
    len_nxt  = len_r;
    oc_nxt   = oc_r;
    fst_nxt  = fst_r;
    busy_nxt = busy_r;
    ctrl_v   = 1'b0;
    cword    = '0;
    tx_v     = 1'b0;
    rd_v     = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = AW'(in_ch.index);
    mem_ra   = AW'(in_ch.index);
    mem_wd   = in_ch.data;
    case (cmd_t'(in_ch.cmd))
      CMD_WR_BUF: begin
        mem_we = idx_ok;
      end
      CMD_START: begin
        if (!busy_r) begin
          len_nxt  = (msz_x < DEPTH_X) ? PW'(in_ch.msg_size) : DEPTH_P;
          oc_nxt   = OC_PENDING;
          fst_nxt  = '0;
          busy_nxt = 1'b1;
          ctrl_v   = 1'b1;
          cword    = CW_EN | CW_IE | CW_INT | CW_STA;
        end
      end
      CMD_RD_BUF: begin
        mem_re = idx_ok;
        rd_v   = idx_ok;
      end
      CMD_EVENT: begin
        if (busy_r) begin
          ctrl_v = 1'b1;
          case (stat)
            ST_START, ST_RSTART, ST_TX_ADDR_ACK, ST_TX_DATA_ACK: begin
              ptr_nxt = base_p;
              if (base_x < len_x && base_x < DEPTH_X) begin
                tx_v    = 1'b1;
                mem_re  = 1'b1;
                mem_ra  = base_p[AW-1:0];
                cword   = CW_EN | CW_IE | CW_INT;
                ptr_nxt = base_p + PW'(1);
              end else begin
                oc_nxt   = OC_SUCCESS;
                busy_nxt = 1'b0;
                cword    = CW_EN | CW_INT | CW_STO;
              end
            end
            ST_RX_DATA_ACK, ST_RX_ADDR_ACK: begin
              if (stat == ST_RX_DATA_ACK) begin
                mem_we = ptr_lt;
                mem_wa = ptr_r[AW-1:0];
              end
              ptr_nxt = rx_p;
              if (rx_x + XW'(1) < len_x) begin
                cword = CW_EN | CW_IE | CW_INT | CW_ACK;
              end else begin
                cword = CW_EN | CW_IE | CW_INT;
              end
            end
            ST_RX_DATA_NACK: begin
              mem_we   = ptr_lt;
              mem_wa   = ptr_r[AW-1:0];
              oc_nxt   = OC_SUCCESS;
              busy_nxt = 1'b0;
              cword    = CW_EN | CW_INT | CW_STO;
            end
            ST_ARB_LOST: begin
              cword = CW_EN | CW_IE | CW_INT | CW_STA;
            end
            default: begin
              oc_nxt   = OC_FAILED;
              fst_nxt  = stat;
              busy_nxt = 1'b0;
              cword    = CW_EN;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      len_r     <= '0;
      oc_r      <= OC_PENDING;
      fst_r     <= '0;
      busy_r    <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc;
      if (acc) begin
        ptr_r  <= ptr_nxt;
        len_r  <= len_nxt;
        oc_r   <= oc_nxt;
        fst_r  <= fst_nxt;
        busy_r <= busy_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (acc && mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_ctrl_v_r <= ctrl_v;
      b_cword_r  <= cword;
      b_tx_r     <= tx_v;
      b_rd_r     <= rd_v;
      b_oc_r     <= oc_nxt;
      b_fst_r    <= fst_nxt;
      b_busy_r   <= busy_nxt;
    end
  end

  always_comb begin
    res_valid       = b_valid_r;
    res.ctrl_valid  = b_ctrl_v_r;
    res.ctrl_word   = b_cword_r;
    res.tx_valid    = b_tx_r;
    res.tx_data     = b_tx_r ? mem_q : 8'h00;
    res.outcome     = b_oc_r;
    res.fail_status = b_fst_r;
    res.busy_res    = b_busy_r;
    res.read_data   = b_rd_r ? mem_q : 8'h00;
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= DEPTH_P)
    else $error("byte pointer beyond buffer depth");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= DEPTH_P)
    else $error("transfer length beyond buffer depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ((OQ_LVL_W + 1)'(oq_level) + (OQ_LVL_W + 1)'(b_valid_r)) <= OQ_FULL)
    else $error("more items in flight than output queue slots");

  a_end_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (oc_r == OC_SUCCESS || oc_r == OC_FAILED))
    else $error("transfer ended while outcome still pending");

  a_tx_has_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_tx_r) |-> (b_ctrl_v_r && !b_rd_r))
    else $error("tx byte without control word or with buffer read");

endmodule

FILE: hdl/i2cmts_out_q.sv
module i2cmts_out_q import i2cmts_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  res_t                push_item,
  i2cmts_out_if.source        out_ch,
  output logic [OQ_LVL_W-1:0] level
);

  res_t                q_r [OQ_DEPTH];
  logic [OQ_IDX_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [OQ_LVL_W-1:0] lvl_r, lvl_nxt;
  logic                pop;
  res_t                head;

  assign pop   = out_ch.valid && out_ch.ready;
  assign level = lvl_r;
  assign head  = q_r[rd_r];

  assign out_ch.valid       = lvl_r != '0;
  assign out_ch.ctrl_valid  = head.ctrl_valid;
  assign out_ch.ctrl_word   = head.ctrl_word;
  assign out_ch.tx_valid    = head.tx_valid;
  assign out_ch.tx_data     = head.tx_data;
  assign out_ch.outcome     = head.outcome;
  assign out_ch.fail_status = head.fail_status;
  assign out_ch.busy_res    = head.busy_res;
  assign out_ch.read_data   = head.read_data;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    lvl_nxt = lvl_r + OQ_LVL_W'(push) - OQ_LVL_W'(pop);
    if (push) begin
      wr_nxt = (wr_r == OQ_IDX_W'(OQ_DEPTH - 1)) ? '0 : wr_r + OQ_IDX_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == OQ_IDX_W'(OQ_DEPTH - 1)) ? '0 : rd_r + OQ_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer.
// in_ch carries one command item per handshake: write a buffer byte, start a
// transfer, report a bus status event, or read a buffer byte. out_ch returns
// exactly one result item per command, in order: control word for the bus
// engine, byte to transmit, transfer outcome, failing status, busy flag and
// buffer read data.
// A result reaches out_ch through the registered result stage (state update
// and buffer access), then the output queue. Throughput: one item per cycle
// while in_ch.ready is high. The buffer is a single-port-write,
// single-port-read memory; each item uses at most one write and one read.
// A three-entry output queue absorbs stalls: while out_ch.ready is low,
// in_ch keeps accepting until the queue and the result stage hold three
// items, then in_ch.ready drops until the receiver takes one.
// Reset clears byte pointer, transfer length, outcome, failing status, busy
// flag and the output queue; buffer contents are undefined until written.
module i2c_master_transfer_sequencer import i2cmts_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUF_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  i2cmts_in_if.sink     in_ch,
  i2cmts_out_if.source  out_ch
);

  logic                res_valid;
  res_t                res;
  logic [OQ_LVL_W-1:0] oq_level;

  i2cmts_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .oq_level  (oq_level),
    .res_valid (res_valid),
    .res       (res)
  );

  i2cmts_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_item (res),
    .out_ch    (out_ch),
    .level     (oq_level)
  );

endmodule

FILE: verif/i2c_master_transfer_sequencer_test.sv
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_test;
  import i2cmts_pkg::*;

  localparam int unsigned DEPTH = BUF_DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned MAX_GAP = 6;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] index;
    logic [7:0] data;
    logic [4:0] msg_size;
    logic [7:0] status;
  } seq_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  i2cmts_in_if  in_ch ();
  i2cmts_out_if out_ch ();

  i2c_master_transfer_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  seq_cmd_t    pending_cmds[$];
  res_t        expected_replies[$];
  seq_cmd_t    drv_cmd;
  int unsigned send_gap;
  int unsigned loaded_cnt;
  int unsigned accepted_cnt;
  int unsigned take_hold;
  int unsigned next_hold;
  int unsigned reply_cnt;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned total_cmds;

  // transfer state as the block should hold it
  logic [7:0] shadow_buf [DEPTH];
  logic [4:0] xfer_ptr;
  logic [4:0] xfer_len;
  outcome_t   xfer_outcome;
  logic [7:0] xfer_fail;
  logic       xfer_busy;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t sequencer_step(seq_cmd_t c);
    res_t       r;
    logic [7:0] st;
    r = '0;
    st = c.status & STATUS_MASK;
    case (c.cmd)
      CMD_WR_BUF: shadow_buf[c.index] = c.data;
      CMD_RD_BUF: r.read_data = shadow_buf[c.index];
      CMD_START: begin
        if (!xfer_busy) begin
          xfer_len = (c.msg_size > DEPTH) ? 5'(DEPTH) : c.msg_size;
          xfer_outcome = OC_PENDING;
          xfer_fail = '0;
          xfer_busy = 1'b1;
          r.ctrl_valid = 1'b1;
          r.ctrl_word = CW_EN | CW_IE | CW_INT | CW_STA;
        end
      end
      CMD_EVENT: begin
        if (xfer_busy) begin
          r.ctrl_valid = 1'b1;
          case (st)
            ST_START, ST_RSTART, ST_TX_ADDR_ACK, ST_TX_DATA_ACK: begin
              if (st == ST_START || st == ST_RSTART) xfer_ptr = '0;
              if (xfer_ptr < xfer_len && xfer_ptr < DEPTH) begin
                r.tx_valid = 1'b1;
                r.tx_data = shadow_buf[xfer_ptr[3:0]];
                r.ctrl_word = CW_EN | CW_IE | CW_INT;
                xfer_ptr = xfer_ptr + 5'd1;
              end else begin
                xfer_outcome = OC_SUCCESS;
                xfer_busy = 1'b0;
                r.ctrl_word = CW_EN | CW_INT | CW_STO;
              end
            end
            ST_RX_DATA_ACK, ST_RX_ADDR_ACK: begin
              if (st == ST_RX_DATA_ACK && xfer_ptr < DEPTH) begin
                shadow_buf[xfer_ptr[3:0]] = c.data;
                xfer_ptr = xfer_ptr + 5'd1;
              end
              if (int'(xfer_ptr) + 1 < int'(xfer_len))
                r.ctrl_word = CW_EN | CW_IE | CW_INT | CW_ACK;
              else
                r.ctrl_word = CW_EN | CW_IE | CW_INT;
            end
            ST_RX_DATA_NACK: begin
              if (xfer_ptr < DEPTH) shadow_buf[xfer_ptr[3:0]] = c.data;
              xfer_outcome = OC_SUCCESS;
              xfer_busy = 1'b0;
              r.ctrl_word = CW_EN | CW_INT | CW_STO;
            end
            ST_ARB_LOST: r.ctrl_word = CW_EN | CW_IE | CW_INT | CW_STA;
            default: begin
              xfer_outcome = OC_FAILED;
              xfer_fail = st;
              xfer_busy = 1'b0;
              r.ctrl_word = CW_EN;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    r.outcome = xfer_outcome;
    r.fail_status = xfer_fail;
    r.busy_res = xfer_busy;
    return r;
  endfunction

  task automatic queue_cmd(cmd_t cmd, logic [3:0] idx, logic [7:0] data,
                           logic [4:0] size, logic [7:0] status);
    seq_cmd_t c;
    c.cmd = cmd;
    c.index = idx;
    c.data = data;
    c.msg_size = size;
    c.status = status;
    pending_cmds.push_back(c);
  endtask

  // low status bits are don't-care, so they are always randomized
  task automatic queue_event(logic [7:0] code);
    queue_cmd(CMD_EVENT, 4'($urandom), 8'($urandom), 5'($urandom),
              code | 8'($urandom_range(0, 3)));
  endtask

  task automatic queue_start(int unsigned size);
    queue_cmd(CMD_START, 4'($urandom), 8'($urandom), 5'(size), 8'($urandom));
  endtask

  function automatic int unsigned pick_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
  endfunction

  task automatic queue_write_transfer();
    int unsigned len;
    int unsigned i;
    repeat ($urandom_range(0, 3))
      queue_cmd(CMD_WR_BUF, 4'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
    len = pick_size();
    queue_start(len);
    if (len > DEPTH) len = DEPTH;
    queue_event(ST_START);
    if ($urandom_range(0, 5) == 0) begin
      queue_event(ST_ARB_LOST);
      queue_event(ST_RSTART);
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        queue_event(8'($urandom));
        break;
      end
      queue_event(i == 0 ? ST_TX_ADDR_ACK : ST_TX_DATA_ACK);
    end
  endtask

  task automatic queue_read_transfer();
    int unsigned len;
    int unsigned n;
    int unsigned i;
    len = pick_size();
    queue_start(len);
    if (len > DEPTH) len = DEPTH;
    queue_event(ST_START);
    if ($urandom_range(0, 5) == 0) begin
      queue_event(ST_ARB_LOST);
      queue_event(ST_RSTART);
    end
    queue_event(ST_RX_ADDR_ACK);
    n = (len >= 2) ? len - 2 : 0;
    // overrun acks bytes past the length and can push the pointer into saturation
    if ($urandom_range(0, 5) == 0) n += $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        queue_event(8'($urandom));
        break;
      end
      queue_event(ST_RX_DATA_ACK);
    end
    queue_event(ST_RX_DATA_NACK);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic check_reply();
    res_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected item, expected none, actual ctrl_word 0x%0h",
               $time, out_ch.ctrl_word);
    end else begin
      want = expected_replies.pop_front();
      check_field("ctrl_valid", 8'(want.ctrl_valid), 8'(out_ch.ctrl_valid));
      check_field("ctrl_word", 8'(want.ctrl_word), 8'(out_ch.ctrl_word));
      check_field("tx_valid", 8'(want.tx_valid), 8'(out_ch.tx_valid));
      check_field("tx_data", want.tx_data, out_ch.tx_data);
      check_field("outcome", 8'(want.outcome), 8'(out_ch.outcome));
      check_field("fail_status", want.fail_status, out_ch.fail_status);
      check_field("busy_res", 8'(want.busy_res), 8'(out_ch.busy_res));
      check_field("read_data", want.read_data, out_ch.read_data);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(sequencer_step(drv_cmd));
        accepted_cnt = accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          drv_cmd = pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= drv_cmd.cmd;
          in_ch.index <= drv_cmd.index;
          in_ch.data <= drv_cmd.data;
          in_ch.msg_size <= drv_cmd.msg_size;
          in_ch.status <= drv_cmd.status;
          send_gap <= ((loaded_cnt / 50) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
          loaded_cnt = loaded_cnt + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      take_hold <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_reply();
        reply_cnt = reply_cnt + 1;
        if (reply_cnt == LONG_HOLD_AT)
          next_hold = LONG_HOLD;
        else if ((reply_cnt / 40) % 4 == 2)
          next_hold = 0;
        else
          next_hold = $urandom_range(0, MAX_GAP);
      end else if (take_hold != 0) begin
        next_hold = take_hold - 1;
      end else begin
        next_hold = 0;
      end
      take_hold <= next_hold;
      out_ch.ready <= (next_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned i;
    int unsigned pick;
    int unsigned target;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WR_BUF;
    in_ch.index = '0;
    in_ch.data = '0;
    in_ch.msg_size = '0;
    in_ch.status = '0;
    out_ch.ready = 1'b0;
    xfer_ptr = '0;
    xfer_len = '0;
    xfer_outcome = OC_PENDING;
    xfer_fail = '0;
    xfer_busy = 1'b0;
    for (i = 0; i < DEPTH; i++) shadow_buf[i] = '0;

    // fill the whole buffer first so that no read ever hits an unwritten entry
    for (i = 0; i < DEPTH; i++)
      queue_cmd(CMD_WR_BUF, 4'(i), (i == 0) ? 8'hFF : (i == DEPTH - 1) ? 8'h00 : 8'($urandom),
                5'($urandom), 8'($urandom));

    queue_cmd(CMD_RD_BUF, 4'd0, 8'($urandom), 5'($urandom), 8'($urandom));
    queue_cmd(CMD_RD_BUF, 4'd15, 8'($urandom), 5'($urandom), 8'($urandom));
    queue_event(ST_START);               // idle, ignored
    queue_start(2);
    queue_start(5);                      // busy, ignored
    queue_event(ST_START);
    queue_event(ST_TX_ADDR_ACK);
    queue_event(ST_TX_DATA_ACK);         // count reached, stop
    queue_start(31);                     // clamped to depth
    queue_event(ST_START);
    queue_event(ST_ARB_LOST);
    queue_event(ST_RSTART);
    queue_event(ST_RX_ADDR_ACK);
    queue_event(ST_RX_DATA_ACK);
    queue_event(ST_RX_DATA_NACK);
    queue_start(1);                      // single byte read: no ack
    queue_event(ST_START);
    queue_event(ST_RX_ADDR_ACK);
    queue_event(ST_RX_DATA_NACK);
    queue_start(0);
    queue_event(ST_START);
    queue_start(2);
    queue_event(8'hFF);                  // bus error
    queue_cmd(CMD_RD_BUF, 4'd1, 8'($urandom), 5'($urandom), 8'($urandom));

    target = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        queue_write_transfer();
      else if (pick < 75)
        queue_read_transfer();
      else if (pick < 88)
        queue_cmd($urandom_range(0, 1) ? CMD_RD_BUF : CMD_WR_BUF, 4'($urandom), 8'($urandom),
                  5'($urandom), 8'($urandom));
      else
        queue_cmd(cmd_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom), 5'($urandom),
                  8'($urandom));
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_cmds) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/i2cmts_pkg.sv
hdl/i2cmts_channels.sv
hdl/i2cmts_core.sv
hdl/i2cmts_out_q.sv
hdl/i2c_master_transfer_sequencer.sv
verif/i2c_master_transfer_sequencer_test.sv
